>>> hdl/servo_status_packet_checker_assert.svh
// Assertion macros for the servo status packet checker.
// Used by modules that include this header; needs clk and rst_n in scope.
`ifndef SERVO_STATUS_PACKET_CHECKER_ASSERT_SVH
`define SERVO_STATUS_PACKET_CHECKER_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define SSPC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define SSPC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/sspc_pkg.sv
// Package for the servo status packet checker: payload and state types, codes.
// No dependencies.
`default_nettype none

package sspc_pkg;

    localparam logic [7:0] HEADER_BYTE = 8'hFF;
    localparam logic [3:0] IDLE_COUNT  = 4'd15;
    localparam logic [3:0] MIN_LEN     = 4'd6;
    localparam logic [3:0] MID_LEN     = 4'd7;
    localparam logic [3:0] MAX_LEN     = 4'd8;
    localparam logic [3:0] POS_ID      = 4'd2;
    localparam logic [3:0] POS_ERROR   = 4'd4;
    localparam logic [3:0] POS_DATA_LO = 4'd5;
    localparam logic [3:0] POS_DATA_HI = 4'd6;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_SERVO    = 2'd1;
    localparam logic [1:0] STATUS_COMM     = 2'd2;
    localparam logic [1:0] STATUS_CHECKSUM = 2'd3;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_start;
        logic [7:0] target_id;
        logic [3:0] frame_length;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  servo_error;
        logic [15:0] read_data;
    } out_item_t;

    typedef struct packed {
        logic [3:0] byte_count;
        logic [7:0] running_sum;
        logic       frame_bad;
        logic [7:0] error_byte;
        logic [7:0] data_low;
        logic [7:0] data_high;
    } frame_state_t;

endpackage

`default_nettype wire

>>> hdl/servo_status_packet_checker.sv
// A transferred byte sits in the input register until it is evaluated; its result, if any,
// is registered in the result register when the evaluation advances.
// Throughput: one byte per cycle, set by the single-pass evaluation between the two
// registers; a result left untaken holds the evaluation, and the input then stalls.
// Reset (rst_n low, asynchronous): both registers empty, frame state cleared to byte 0.
// Depends on sspc_pkg, sspc_frame_eval and servo_status_packet_checker_assert.svh.
`default_nettype none

module servo_status_packet_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  sspc_pkg::in_item_t  item,
    output logic                result_valid,
    input  logic                result_ready,
    output sspc_pkg::out_item_t result
);
    import sspc_pkg::*;

    `include "servo_status_packet_checker_assert.svh"

    // Input register: holds the byte of the last transfer until it is evaluated.
    logic         in_valid_reg;
    in_item_t     in_item_reg;

    // Frame state carried from byte to byte.
    frame_state_t state_reg;
    frame_state_t state_next;

    // Result register, acting as the output stage.
    logic         out_valid_reg;
    logic         out_valid_next;
    out_item_t    out_item_reg;

    logic         eval_emit;
    out_item_t    eval_result;
    logic         advance;
    logic         eval_fire;

    // The evaluation stage may move on whenever the result register is free or is
    // being emptied in this cycle, even when the byte produces no result.
    assign advance    = !out_valid_reg || result_ready;
    assign eval_fire  = in_valid_reg && advance;
    assign item_ready = !in_valid_reg || advance;

    sspc_frame_eval u_eval (
        .item       (in_item_reg),
        .state_now  (state_reg),
        .state_next (state_next),
        .emit       (eval_emit),
        .result     (eval_result)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (result_valid && result_ready)
            out_valid_next = 1'b0;
        if (eval_fire && eval_emit)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (item_ready)
                in_valid_reg <= item_valid;
            out_valid_reg <= out_valid_next;
            if (eval_fire)
                state_reg <= state_next;
        end
    end

    // Payload registers carry no reset; they are only read while marked valid.
    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
            in_item_reg <= item;
        if (eval_fire && eval_emit)
            out_item_reg <= eval_result;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_item_reg;

    // Every result closes its frame: the byte position drops to idle.
    `SSPC_ASSERT_NOW(a_emit_goes_idle, eval_fire && eval_emit, state_next.byte_count == IDLE_COUNT, "result emitted without returning to idle")

    // With an empty result register the block must always take a byte.
    `SSPC_ASSERT_NOW(a_ready_when_empty, !out_valid_reg, item_ready, "input stalled while the result register is empty")

    // An evaluated result is presented in the following cycle.
    `SSPC_ASSERT_NEXT(a_result_follows, eval_fire && eval_emit, result_valid, "evaluated result not presented")

    // Data is reported only with an ok status.
    `SSPC_ASSERT_NOW(a_data_only_when_ok, result_valid && (result.status != STATUS_OK), result.read_data == 16'd0, "read data nonzero on a failed packet")

endmodule

`default_nettype wire

>>> hdl/sspc_frame_eval.sv
// Per-byte evaluation of a status packet: next frame state and the result.
// Depends on sspc_pkg.
`default_nettype none

module sspc_frame_eval (
    input  sspc_pkg::in_item_t     item,
    input  sspc_pkg::frame_state_t state_now,
    output sspc_pkg::frame_state_t state_next,
    output logic                   emit,
    output sspc_pkg::out_item_t    result
);
    import sspc_pkg::*;

    logic [3:0]   len;
    logic [3:0]   last;
    logic [3:0]   pos;
    logic [7:0]   expect_sum;
    frame_state_t base;

    always_comb
    begin
        if (item.frame_length < MIN_LEN)
            len = MIN_LEN;
        else if (item.frame_length > MAX_LEN)
            len = MAX_LEN;
        else
            len = item.frame_length;
        last = len - 4'd1;

        // A start mark clears the frame before this byte is looked at.
        if (item.frame_start)
            base = '0;
        else
            base = state_now;
        pos = base.byte_count;

        state_next = base;
        emit       = 1'b0;
        result     = '0;
        expect_sum = ~base.running_sum;

        if (pos > last)
        begin
            state_next.byte_count = IDLE_COUNT;
        end
        else if (pos < last)
        begin
            if ((pos < POS_ID) && (item.rx_byte != HEADER_BYTE))
                state_next.frame_bad = 1'b1;
            if ((pos == POS_ID) && (item.rx_byte != item.target_id))
                state_next.frame_bad = 1'b1;
            if (pos >= POS_ID)
                state_next.running_sum = base.running_sum + item.rx_byte;
            if (pos == POS_ERROR)
                state_next.error_byte = item.rx_byte;
            if (pos == POS_DATA_LO)
                state_next.data_low = item.rx_byte;
            if (pos == POS_DATA_HI)
                state_next.data_high = item.rx_byte;
            state_next.byte_count = pos + 4'd1;
        end
        else
        begin
            emit = 1'b1;
            if (base.frame_bad)
                result.status = STATUS_COMM;
            else if (expect_sum != item.rx_byte)
                result.status = STATUS_CHECKSUM;
            else if (base.error_byte != 8'd0)
                result.status = STATUS_SERVO;
            else
                result.status = STATUS_OK;
            result.servo_error = base.error_byte;
            if (result.status == STATUS_OK)
            begin
                if (len == MID_LEN)
                    result.read_data = {8'd0, base.data_low};
                else if (len == MAX_LEN)
                    result.read_data = {base.data_high, base.data_low};
            end
            state_next.byte_count = IDLE_COUNT;
        end
    end

endmodule

`default_nettype wire
